### sv/assert_macros.svh
// Assertion macros used by the RTL top level, heap_block_allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is low.
`define HBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent.
`define HBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hba_pkg.sv
`default_nettype none
package hba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 32;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NULL     = 2'd1,
    STAT_NO_SPACE = 2'd2,
    STAT_BAD_FREE = 2'd3
  } hba_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_ALLOC_END,
    S_NEXT_RD,
    S_NEXT_CAP,
    S_MERGE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } hba_state_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
  } hba_in_t;

  typedef struct packed {
    logic [15:0] data_address;
    hba_status_e status;
  } hba_out_t;

  typedef struct packed {
    logic        load;
    logic        rd_idx;
    logic        rd_next;
    logic        scan_step;
    logic        capture_k;
    logic        capture_next;
    logic        alloc_end;
    logic        free_merge;
    logic        shift_wr;
    logic        set_res;
    hba_status_e res_code;
    logic        out_load;
  } hba_cmd_t;

  typedef struct packed {
    logic in_null;
    logic in_free;
    logic op_free;
    logic tbl_empty;
    logic last_entry;
    logic stop_hit;
    logic addr_hit;
    logic cur_free;
    logic has_next;
    logic shift_none;
    logic shift_last;
    logic out_free;
  } hba_stat_t;

endpackage
`default_nettype wire

### sv/hba_ctrl.sv
`default_nettype none
module hba_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hba_pkg::hba_stat_t stat_i,
  output hba_pkg::hba_cmd_t      cmd_o
);
  import hba_pkg::*;

  hba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.res_code = STAT_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.in_null) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_code = STAT_NULL;
            state_d = S_DONE;
          end else if (stat_i.tbl_empty) begin
            if (stat_i.in_free) begin
              cmd_o.set_res = 1'b1;
              cmd_o.res_code = STAT_BAD_FREE;
              state_d = S_DONE;
            end else begin
              state_d = S_ALLOC_END;
            end
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.op_free) begin
          if (stat_i.addr_hit) begin
            cmd_o.capture_k = 1'b1;
            if (stat_i.cur_free) begin
              cmd_o.set_res = 1'b1;
              cmd_o.res_code = STAT_BAD_FREE;
              state_d = S_DONE;
            end else if (stat_i.has_next) begin
              state_d = S_NEXT_RD;
            end else begin
              state_d = S_MERGE;
            end
          end else begin
            cmd_o.scan_step = 1'b1;
            if (stat_i.last_entry) begin
              cmd_o.set_res = 1'b1;
              cmd_o.res_code = STAT_BAD_FREE;
              state_d = S_DONE;
            end else begin
              state_d = S_RD;
            end
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.stop_hit || stat_i.last_entry) begin
            state_d = S_ALLOC_END;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_ALLOC_END: begin
        cmd_o.alloc_end = 1'b1;
        state_d = S_DONE;
      end
      S_NEXT_RD: begin
        cmd_o.rd_next = 1'b1;
        state_d = S_NEXT_CAP;
      end
      S_NEXT_CAP: begin
        cmd_o.capture_next = 1'b1;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.free_merge = 1'b1;
        if (stat_i.shift_none) begin
          cmd_o.set_res = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        if (stat_i.shift_last) begin
          cmd_o.set_res = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/hba_datapath.sv
`default_nettype none
module hba_datapath #(
  parameter int MaxBlocks   = 64,
  parameter int HeapBytes   = 65536,
  parameter int HeaderBytes = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hba_pkg::hba_cmd_t  cmd_i,
  output hba_pkg::hba_stat_t      stat_o,
  input  wire hba_pkg::hba_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hba_pkg::hba_out_t       out_data_o,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_index_i,
  input  wire logic [16:0]        cfg_data_i
);
  import hba_pkg::*;

  localparam int IW  = $clog2(MaxBlocks);
  localparam int CW  = $clog2(MaxBlocks + 1);
  localparam int HW  = $clog2(HeapBytes + 1);
  localparam int LW  = (HW > 17) ? HW : 17;
  localparam int EW  = LW + 1;
  localparam int GW  = LW + 2;
  localparam logic [LW-1:0] HDR    = LW'(HeaderBytes);
  localparam logic [CW-1:0] MAXC   = CW'(MaxBlocks);
  localparam logic [GW-1:0] HEAP_G = GW'(HeapBytes);

  // Each table entry holds {length, free mark}.
  logic [EW-1:0] mem_q [MaxBlocks];
  logic [EW-1:0] rd_q;

  logic [CW-1:0] count_q, resume_q;
  logic [LW-1:0] top_q;
  logic [1:0]    policy_q;
  logic [16:0]   limit_q;
  logic          mode_q;
  logic [LW-1:0] size_q;
  logic [15:0]   rel_q;
  logic [IW-1:0] idx_q;
  logic [LW-1:0] acc_q;
  logic          found_q;
  logic [IW-1:0] fidx_q;
  logic [LW-1:0] flen_q, faddr_q;
  logic          prev_free_q, next_free_q;
  logic [LW-1:0] prev_len_q, next_len_q, cur_len_q;
  logic [1:0]    shift_r_q;
  logic          out_valid_q;
  hba_out_t      out_q, res_q;

  logic [16:0]   req_round;
  logic [LW-1:0] e_len;
  logic          e_free;
  logic [CW-1:0] start_idx, idx_c;
  logic          candidate, better;
  logic [GW-1:0] need, lim;
  logic          grow_ok;
  logic [1:0]    merge_r;
  logic [LW-1:0] new_len;
  logic [IW-1:0] survivor, shift_dst;
  logic [CW:0]   shift_src;
  logic [CW-1:0] res_adj1, res_adj2;
  logic          mem_we, rd_en;
  logic [IW-1:0] mem_wa, rd_a;
  logic [EW-1:0] mem_wd;

  assign req_round = ({1'b0, in_data_i.request_bytes} + 17'd3) & ~17'd3;
  assign e_len  = rd_q[EW-1:1];
  assign e_free = rd_q[0];
  assign idx_c  = CW'(idx_q);

  assign start_idx = (policy_q == FIT_NEXT && resume_q < count_q) ? resume_q : '0;
  assign candidate = e_free && (e_len >= size_q) && (idx_c >= start_idx);
  assign better = !found_q || (policy_q == FIT_BEST && e_len < flen_q) ||
                  (policy_q == FIT_WORST && e_len > flen_q);

  assign need = GW'(top_q) + GW'(HDR) + GW'(size_q);
  assign lim  = (GW'(limit_q) < HEAP_G) ? GW'(limit_q) : HEAP_G;
  assign grow_ok = (count_q < MAXC) && (need <= lim);

  assign merge_r  = {1'b0, next_free_q} + {1'b0, prev_free_q};
  assign new_len  = cur_len_q + (next_free_q ? HDR + next_len_q : '0) +
                    (prev_free_q ? prev_len_q + HDR : '0);
  assign survivor = prev_free_q ? idx_q - IW'(1) : idx_q;
  assign shift_src = (CW+1)'(idx_q) + (CW+1)'(1) + (CW+1)'(next_free_q);
  assign shift_dst = idx_q - IW'(shift_r_q);

  // Entries above an absorbed one move down, so the next-fit mark follows them.
  always_comb begin
    res_adj1 = resume_q;
    if (next_free_q && resume_q < MAXC && resume_q >= idx_c + CW'(1)) begin
      res_adj1 = resume_q - CW'(1);
    end
    res_adj2 = res_adj1;
    if (prev_free_q && res_adj1 < MAXC && res_adj1 >= idx_c) begin
      res_adj2 = res_adj1 - CW'(1);
    end
  end

  always_comb begin
    stat_o.in_null = (in_data_i.mode == MODE_FREE) ? (in_data_i.release_address == 16'd0)
                                                   : (in_data_i.request_bytes == 16'd0);
    stat_o.in_free    = (in_data_i.mode == MODE_FREE);
    stat_o.op_free    = (mode_q == MODE_FREE);
    stat_o.tbl_empty  = (count_q == '0);
    stat_o.last_entry = (idx_c + CW'(1) == count_q);
    stat_o.stop_hit   = candidate && (policy_q == FIT_FIRST || policy_q == FIT_NEXT);
    stat_o.addr_hit   = (acc_q + HDR) == LW'(rel_q);
    stat_o.cur_free   = e_free;
    stat_o.has_next   = (idx_c + CW'(1) < count_q);
    stat_o.shift_none = (merge_r == 2'd0) || (shift_src >= (CW+1)'(count_q));
    stat_o.shift_last = ((CW+1)'(idx_q) + (CW+1)'(1) ==
                         (CW+1)'(count_q) + (CW+1)'(shift_r_q));
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (cmd_i.alloc_end) begin
      if (found_q) begin
        mem_we = 1'b1;
        mem_wa = fidx_q;
        mem_wd = {flen_q, 1'b0};
      end else if (grow_ok) begin
        mem_we = 1'b1;
        mem_wa = count_q[IW-1:0];
        mem_wd = {size_q, 1'b0};
      end
    end else if (cmd_i.free_merge) begin
      mem_we = 1'b1;
      mem_wa = survivor;
      mem_wd = {new_len, 1'b1};
    end else if (cmd_i.shift_wr) begin
      mem_we = 1'b1;
      mem_wa = shift_dst;
      mem_wd = rd_q;
    end
  end

  assign rd_en = cmd_i.rd_idx || cmd_i.rd_next;
  assign rd_a  = cmd_i.rd_next ? idx_q + IW'(1) : idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      top_q       <= '0;
      resume_q    <= MAXC;
      policy_q    <= FIT_FIRST;
      limit_q     <= 17'h10000;
      found_q     <= 1'b0;
      prev_free_q <= 1'b0;
      next_free_q <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_ALLOC;
      idx_q       <= '0;
      shift_r_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_FIT_POLICY) begin
          policy_q <= cfg_data_i[1:0];
        end else begin
          limit_q <= cfg_data_i;
        end
      end
      if (cmd_i.load) begin
        mode_q      <= in_data_i.mode;
        idx_q       <= '0;
        found_q     <= 1'b0;
        prev_free_q <= 1'b0;
        next_free_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + IW'(1);
        if (mode_q == MODE_ALLOC && candidate && better) begin
          found_q <= 1'b1;
        end
        prev_free_q <= e_free;
      end
      if (cmd_i.capture_next) begin
        next_free_q <= e_free;
      end
      if (cmd_i.alloc_end) begin
        if (policy_q == FIT_NEXT) begin
          resume_q <= found_q ? CW'(fidx_q) : MAXC;
        end
        if (!found_q && grow_ok) begin
          count_q <= count_q + CW'(1);
          top_q   <= LW'(need);
        end
      end
      if (cmd_i.free_merge) begin
        count_q   <= count_q - CW'(merge_r);
        resume_q  <= res_adj2;
        shift_r_q <= merge_r;
        idx_q     <= shift_src[IW-1:0];
      end
      if (cmd_i.shift_wr) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q <= LW'(req_round);
      rel_q  <= in_data_i.release_address;
      acc_q  <= '0;
    end
    if (cmd_i.scan_step) begin
      acc_q <= acc_q + HDR + e_len;
      if (mode_q == MODE_ALLOC && candidate && better) begin
        fidx_q  <= idx_q;
        flen_q  <= e_len;
        faddr_q <= acc_q + HDR;
      end
      prev_len_q <= e_len;
    end
    if (cmd_i.capture_k) begin
      cur_len_q <= e_len;
    end
    if (cmd_i.capture_next) begin
      next_len_q <= e_len;
    end
    if (cmd_i.set_res) begin
      res_q.data_address <= 16'd0;
      res_q.status       <= cmd_i.res_code;
    end
    if (cmd_i.alloc_end) begin
      if (found_q) begin
        res_q.data_address <= faddr_q[15:0];
        res_q.status       <= STAT_DONE;
      end else if (grow_ok) begin
        res_q.data_address <= 16'(top_q + HDR);
        res_q.status       <= STAT_DONE;
      end else begin
        res_q.data_address <= 16'd0;
        res_q.status       <= STAT_NO_SPACE;
      end
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### sv/heap_block_allocator.sv
// Each table entry scanned is read and then evaluated; a free that merges then
// reads and writes back each entry that moves down.
// One request at a time: no new request is taken until the last result is loaded for output,
// and the table memory is read and then evaluated one entry at a time.
// Reset (asynchronous, active low) empties the table, zeroes the heap top and
// restores first fit and a 65536-byte limit; the table memory itself is not cleared.
`default_nettype none
`include "assert_macros.svh"
module heap_block_allocator #(
  parameter int MaxBlocks   = hba_pkg::MAX_BLOCKS_DEF,
  parameter int HeapBytes   = hba_pkg::HEAP_BYTES_DEF,
  parameter int HeaderBytes = hba_pkg::HEADER_BYTES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire hba_pkg::hba_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output hba_pkg::hba_out_t     out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [16:0]      cfg_data_i
);
  import hba_pkg::*;

  hba_cmd_t  cmd;
  hba_stat_t stat;

  assign cfg_ready_o = 1'b1;

  hba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hba_datapath #(
    .MaxBlocks   (MaxBlocks),
    .HeapBytes   (HeapBytes),
    .HeaderBytes (HeaderBytes)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // An accepted request keeps the block busy until its result is loaded.
  `HBA_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "idle after request")
  // A waiting result is never overwritten.
  `HBA_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_o || !out_stall_i), "result lost")
  // Only one source writes the table in a cycle.
  `HBA_ASSERT(a_one_writer, $onehot0({cmd.alloc_end, cmd.free_merge, cmd.shift_wr}), "two writers")

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

class heap_scoreboard;
  localparam int NBLK = hba_pkg::MAX_BLOCKS_DEF;
  localparam int HDR  = hba_pkg::HEADER_BYTES_DEF;
  localparam int HEAP = hba_pkg::HEAP_BYTES_DEF;

  int unsigned  blk_len[NBLK];
  bit           blk_free[NBLK];
  int unsigned  blk_cnt;
  int unsigned  top;
  int unsigned  resume;
  logic [1:0]   policy;
  int unsigned  limit;
  hba_pkg::hba_out_t pending[$];
  int           errors;
  int           n_checked;
  int           n_grant;
  int           n_merge;

  function new();
    blk_cnt = 0;
    top = 0;
    resume = NBLK;
    policy = hba_pkg::FIT_FIRST;
    limit = 65536;
    errors = 0;
    n_checked = 0;
    n_grant = 0;
    n_merge = 0;
  endfunction

  function void set_reg(logic idx, logic [16:0] val);
    if (idx == hba_pkg::CFG_FIT_POLICY) policy = val[1:0];
    else limit = val;
  endfunction

  function void absorb(int unsigned k);
    blk_len[k-1] += HDR + blk_len[k];
    for (int unsigned i = k; i + 1 < blk_cnt; i++) begin
      blk_len[i] = blk_len[i+1];
      blk_free[i] = blk_free[i+1];
    end
    blk_cnt--;
    n_merge++;
    if (resume < NBLK && resume >= k) resume--;
  endfunction

  function int unsigned choose(int unsigned sz);
    int unsigned hit;
    int unsigned first;
    hit = NBLK;
    first = 0;
    if (policy == hba_pkg::FIT_NEXT && resume < blk_cnt) first = resume;
    for (int unsigned i = first; i < blk_cnt; i++) begin
      if (!blk_free[i] || blk_len[i] < sz) continue;
      if (hit == NBLK) begin
        hit = i;
        if (policy == hba_pkg::FIT_FIRST || policy == hba_pkg::FIT_NEXT) break;
      end else if (policy == hba_pkg::FIT_BEST && blk_len[i] < blk_len[hit]) begin
        hit = i;
      end else if (policy == hba_pkg::FIT_WORST && blk_len[i] > blk_len[hit]) begin
        hit = i;
      end
    end
    if (policy == hba_pkg::FIT_NEXT) resume = hit;
    return hit;
  endfunction

  // Works out the answer to an accepted request and queues it.
  function void note_request(hba_pkg::hba_in_t rq);
    hba_pkg::hba_out_t r;
    int unsigned sz, k, a, cap;
    r.data_address = '0;
    r.status = hba_pkg::STAT_DONE;
    if (rq.mode == hba_pkg::MODE_ALLOC) begin
      if (rq.request_bytes == 0) begin
        r.status = hba_pkg::STAT_NULL;
      end else begin
        sz = (int'(rq.request_bytes) + 3) & ~3;
        k = choose(sz);
        if (k < blk_cnt) begin
          blk_free[k] = 1'b0;
          a = 0;
          for (int unsigned i = 0; i < k; i++) a += HDR + blk_len[i];
          r.data_address = 16'(a + HDR);
          n_grant++;
        end else begin
          cap = (limit > HEAP) ? HEAP : limit;
          if (blk_cnt >= NBLK || top + HDR + sz > cap) begin
            r.status = hba_pkg::STAT_NO_SPACE;
          end else begin
            blk_len[blk_cnt] = sz;
            blk_free[blk_cnt] = 1'b0;
            blk_cnt++;
            r.data_address = 16'(top + HDR);
            top += HDR + sz;
            n_grant++;
          end
        end
      end
    end else if (rq.release_address == 0) begin
      r.status = hba_pkg::STAT_NULL;
    end else begin
      a = 0;
      k = NBLK;
      for (int unsigned i = 0; i < blk_cnt; i++) begin
        if (a + HDR == rq.release_address) begin
          k = i;
          break;
        end
        a += HDR + blk_len[i];
      end
      if (k >= blk_cnt || blk_free[k]) begin
        r.status = hba_pkg::STAT_BAD_FREE;
      end else begin
        blk_free[k] = 1'b1;
        if (k + 1 < blk_cnt && blk_free[k+1]) absorb(k + 1);
        if (k >= 1 && blk_free[k-1]) absorb(k);
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(hba_pkg::hba_out_t got);
    hba_pkg::hba_out_t exp;
    if (pending.size() == 0) begin
      $error("unexpected result: data_address %0d status %0d", got.data_address, got.status);
      errors++;
      return;
    end
    exp = pending.pop_front();
    n_checked++;
    if (got.data_address !== exp.data_address) begin
      $error("data_address: expected %0d, got %0d", exp.data_address, got.data_address);
      errors++;
    end
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      errors++;
    end
  endfunction

  // Picks the data offset of a block (only busy ones when busy_only is set), or 0 when there is none.
  function logic [15:0] some_address(bit busy_only);
    int unsigned a, pick, seen;
    int unsigned offs[$];
    a = 0;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (!busy_only || !blk_free[i]) offs.push_back(a + HDR);
      a += HDR + blk_len[i];
    end
    if (offs.size() == 0) return 16'd0;
    pick = $urandom_range(offs.size() - 1);
    seen = offs[pick];
    return 16'(seen);
  endfunction
endclass

module testbench;
  import hba_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  hba_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  hba_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;

  heap_scoreboard heap_sb;
  int          idle_cycles = 0;
  bit          drain_done = 1'b0;

  heap_block_allocator u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i,
    .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(3);
    return $urandom_range(40, 8);
  endfunction

  // Result side: random stalls, checking each accepted result.
  initial begin
    int hold;
    heap_sb = new();
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) heap_sb.check_result(out_data_o);
      if (drain_done) begin
        out_stall_i <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(99) < 20) begin
        hold = gap_len();
        out_stall_i <= (hold != 0);
        if (hold != 0) hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or register write.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // The block stays busy after each request, so valid is
  // always dropped between two requests.
  task automatic send(hba_in_t rq);
    int g;
    g = gap_len();
    repeat (g + 1) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    do @(posedge clk_i); while (in_stall_o);
    heap_sb.note_request(rq);
    in_valid_i <= 1'b0;
  endtask

  task automatic alloc(int unsigned n);
    hba_in_t rq;
    rq.mode = MODE_ALLOC;
    rq.request_bytes = 16'(n);
    rq.release_address = 16'($urandom);
    send(rq);
  endtask

  task automatic release_at(logic [15:0] a);
    hba_in_t rq;
    rq.mode = MODE_FREE;
    rq.request_bytes = 16'($urandom);
    rq.release_address = a;
    send(rq);
  endtask

  task automatic wait_quiet();
    while (heap_sb.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    heap_sb.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly small allocations and frees of live blocks, with some noise.
  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) alloc($urandom_range(1, 200));
      else if (r < 45) alloc($urandom_range(65535));
      else if (r < 48) alloc(0);
      else if (r < 85) release_at(heap_sb.some_address(1'b1));
      else if (r < 92) release_at(heap_sb.some_address(1'b0));
      else release_at(16'($urandom));
    end
  endtask

  initial begin
    logic [1:0] pol;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero sizes, null and bad frees, rounding, merges, limit hit.
    alloc(0);
    release_at(16'd0);
    release_at(16'hFFFF);
    alloc(1);
    alloc(4);
    alloc(5);
    alloc(16'hFFFF);
    alloc(100);
    alloc(8);
    release_at(16'd32);
    release_at(16'd32);
    release_at(16'd100);
    release_at(16'd68);
    alloc(30);
    alloc(3);
    release_at(heap_sb.some_address(1'b1));
    release_at(heap_sb.some_address(1'b1));
    alloc(16'h8000);
    alloc(16'h7FFF);
    wait_quiet();

    write_reg(CFG_HEAP_LIMIT, 17'd0);
    alloc(1);
    wait_quiet();
    write_reg(CFG_HEAP_LIMIT, 17'h1FFFF);
    alloc(2);
    wait_quiet();

    for (int ph = 0; ph < 10; ph++) begin
      pol = 2'(ph % 4);
      write_reg(CFG_FIT_POLICY, 17'(pol));
      case (ph)
        3: begin
          write_reg(CFG_HEAP_LIMIT, 17'd65536);
        end
        5: begin
          write_reg(CFG_HEAP_LIMIT, 17'd4096);
        end
        default: begin
          write_reg(CFG_HEAP_LIMIT, 17'($urandom_range(65536, 2048)));
        end
      endcase
      random_phase(170);
      wait_quiet();
    end

    wait_quiet();
    drain_done = 1'b1;
    @(posedge clk_i);
    $display("Checked %0d results: %0d grants, %0d merges, all four fit policies.",
             heap_sb.n_checked, heap_sb.n_grant, heap_sb.n_merge);
    if (heap_sb.errors == 0 && heap_sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
